### rtl/hsv_window_blob_centroid_core_assert.svh
// Assertion helpers for the blob centroid core.
`ifndef HSV_WINDOW_BLOB_CENTROID_CORE_ASSERT_SVH
`define HSV_WINDOW_BLOB_CENTROID_CORE_ASSERT_SVH

// Clocked check, muted while reset is asserted.
`define HSVBC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, with the usual clock and reset names.
`define HSVBC_CHECK(label, prop, msg) \
  `HSVBC_ASSERT(label, clk, rst_n, prop, msg)

`endif

### rtl/hsvbc_pkg.sv
`default_nettype none

package hsvbc_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;

  localparam int SUM_W   = 24;
  localparam int COUNT_W = 17;
  localparam int MINPX_W = 10;
  localparam int PADDR_W = 5;
  localparam int QUOT_W  = 8;

  localparam logic [7:0]         HUE_MAX_RST = 8'd255;
  localparam logic [7:0]         HUE_MIN_RST = 8'd0;
  localparam logic [7:0]         SAT_MAX_RST = 8'd255;
  localparam logic [7:0]         SAT_MIN_RST = 8'd0;
  localparam logic [7:0]         VAL_MAX_RST = 8'd255;
  localparam logic [7:0]         VAL_MIN_RST = 8'd225;
  localparam logic [MINPX_W-1:0] MINPX_RST   = 10'd13;

  typedef enum logic [2:0] {
    REG_HUE_MAX = 3'd0,
    REG_HUE_MIN = 3'd1,
    REG_SAT_MAX = 3'd2,
    REG_SAT_MIN = 3'd3,
    REG_VAL_MAX = 3'd4,
    REG_VAL_MIN = 3'd5,
    REG_MINPX   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic [7:0] col;
    logic [7:0] row;
    logic       frame_end;
  } pix_t;

  typedef struct packed {
    logic               object_found;
    logic [7:0]         centroid_col;
    logic [7:0]         centroid_row;
    logic [COUNT_W-1:0] pixel_count;
  } res_t;

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_DIVC = 4'b0010,
    ST_DIVR = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

### rtl/hsv_window_blob_centroid_core.sv
// Pixels that are not the frame's last are taken one per cycle while no result is
// pending, and summed as they are taken. The frame's last pixel stalls the input: when
// an object is found the result follows two 8-step mean divisions on one shared
// compare/subtract unit and the result stage; when not, the result stage issues it.
// Synchronous active-low reset clears sums, count and handshake state and loads the
// default color window (value 225..255, any hue and saturation) and count threshold 13.
`default_nettype none

`include "hsv_window_blob_centroid_core_assert.svh"

module hsv_window_blob_centroid_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire hsvbc_pkg::pix_t               in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output hsvbc_pkg::res_t                    out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hsvbc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int SW = hsvbc_pkg::SUM_W;
  localparam int CW = hsvbc_pkg::COUNT_W;
  localparam int QW = hsvbc_pkg::QUOT_W;

  // configuration
  logic [7:0] hue_max_r, hue_min_r, sat_max_r, sat_min_r, val_max_r, val_min_r;
  logic [hsvbc_pkg::MINPX_W-1:0] minpx_r;
  logic                          cfg_wr;
  hsvbc_pkg::reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = hsvbc_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_max_r <= hsvbc_pkg::HUE_MAX_RST;
      hue_min_r <= hsvbc_pkg::HUE_MIN_RST;
      sat_max_r <= hsvbc_pkg::SAT_MAX_RST;
      sat_min_r <= hsvbc_pkg::SAT_MIN_RST;
      val_max_r <= hsvbc_pkg::VAL_MAX_RST;
      val_min_r <= hsvbc_pkg::VAL_MIN_RST;
      minpx_r   <= hsvbc_pkg::MINPX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        hsvbc_pkg::REG_HUE_MAX: hue_max_r <= pwdata[7:0];
        hsvbc_pkg::REG_HUE_MIN: hue_min_r <= pwdata[7:0];
        hsvbc_pkg::REG_SAT_MAX: sat_max_r <= pwdata[7:0];
        hsvbc_pkg::REG_SAT_MIN: sat_min_r <= pwdata[7:0];
        hsvbc_pkg::REG_VAL_MAX: val_max_r <= pwdata[7:0];
        hsvbc_pkg::REG_VAL_MIN: val_min_r <= pwdata[7:0];
        hsvbc_pkg::REG_MINPX:   minpx_r   <= pwdata[hsvbc_pkg::MINPX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      hsvbc_pkg::REG_HUE_MAX: prdata = {24'd0, hue_max_r};
      hsvbc_pkg::REG_HUE_MIN: prdata = {24'd0, hue_min_r};
      hsvbc_pkg::REG_SAT_MAX: prdata = {24'd0, sat_max_r};
      hsvbc_pkg::REG_SAT_MIN: prdata = {24'd0, sat_min_r};
      hsvbc_pkg::REG_VAL_MAX: prdata = {24'd0, val_max_r};
      hsvbc_pkg::REG_VAL_MIN: prdata = {24'd0, val_min_r};
      hsvbc_pkg::REG_MINPX:   prdata = {22'd0, minpx_r};
      default:                prdata = 32'd0;
    endcase
  end

  // pixel classification and saturating accumulation
  hsvbc_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]     col_sum_r, col_sum_nxt, row_sum_r, row_sum_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              in_acc, marked;
  logic [SW:0]       col_add, row_add;
  logic [CW:0]       cnt_add;
  logic [SW-1:0]     col_upd, row_upd;
  logic [CW-1:0]     cnt_upd;

  assign in_stall = (state_r != hsvbc_pkg::ST_RUN);
  assign in_acc   = in_valid && !in_stall;

  assign marked = (in_data.hue >= hue_min_r) && (in_data.hue <= hue_max_r) &&
                  (in_data.saturation >= sat_min_r) && (in_data.saturation <= sat_max_r) &&
                  (in_data.brightness >= val_min_r) && (in_data.brightness <= val_max_r) &&
                  (32'(in_data.col) < hsvbc_pkg::MAX_COLS) &&
                  (32'(in_data.row) < hsvbc_pkg::MAX_ROWS);

  assign col_add = {1'b0, col_sum_r} + (SW+1)'(in_data.col);
  assign row_add = {1'b0, row_sum_r} + (SW+1)'(in_data.row);
  assign cnt_add = {1'b0, cnt_r} + (CW+1)'(1);
  assign col_upd = !marked ? col_sum_r : (col_add[SW] ? '1 : col_add[SW-1:0]);
  assign row_upd = !marked ? row_sum_r : (row_add[SW] ? '1 : row_add[SW-1:0]);
  assign cnt_upd = !marked ? cnt_r : (cnt_add[CW] ? '1 : cnt_add[CW-1:0]);

  // shared divider: restoring, one quotient bit per cycle, quotient always below 256
  logic [SW-1:0] rem_r, rem_nxt, dsh_r, dsh_nxt, row_hold_r, row_hold_nxt;
  logic [CW-1:0] cnt_hold_r, cnt_hold_nxt;
  logic [QW-1:0] q_r, q_nxt, qcol_r, qcol_nxt;
  logic [2:0]    step_r, step_nxt;
  logic          found_r, found_nxt;
  logic          ge;
  logic          out_valid_r, out_valid_nxt;
  hsvbc_pkg::res_t out_r, out_nxt;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    state_nxt     = state_r;
    col_sum_nxt   = col_sum_r;
    row_sum_nxt   = row_sum_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    row_hold_nxt  = row_hold_r;
    cnt_hold_nxt  = cnt_hold_r;
    q_nxt         = q_r;
    qcol_nxt      = qcol_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    unique case (state_r) inside
      hsvbc_pkg::ST_RUN: begin
        if (in_acc) begin
          if (in_data.frame_end) begin
            // latch the frame totals and free the accumulators at once
            found_nxt    = (cnt_upd > CW'(minpx_r));
            cnt_hold_nxt = cnt_upd;
            rem_nxt      = col_upd;
            row_hold_nxt = row_upd;
            dsh_nxt      = {cnt_upd, 7'd0};
            step_nxt     = 3'd7;
            col_sum_nxt  = '0;
            row_sum_nxt  = '0;
            cnt_nxt      = '0;
            state_nxt    = (cnt_upd > CW'(minpx_r)) ? hsvbc_pkg::ST_DIVC
                                                    : hsvbc_pkg::ST_OUT;
          end else begin
            col_sum_nxt = col_upd;
            row_sum_nxt = row_upd;
            cnt_nxt     = cnt_upd;
          end
        end
      end
      hsvbc_pkg::ST_DIVC, hsvbc_pkg::ST_DIVR: begin
        q_nxt    = {q_r[QW-2:0], ge};
        rem_nxt  = ge ? (rem_r - dsh_r) : rem_r;
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r - 3'd1;
        if (step_r == 3'd0) begin
          if (state_r == hsvbc_pkg::ST_DIVC) begin
            qcol_nxt  = {q_r[QW-2:0], ge};
            rem_nxt   = row_hold_r;
            dsh_nxt   = {cnt_hold_r, 7'd0};
            step_nxt  = 3'd7;
            state_nxt = hsvbc_pkg::ST_DIVR;
          end else begin
            state_nxt = hsvbc_pkg::ST_OUT;
          end
        end
      end
      hsvbc_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.object_found = found_r;
          out_nxt.centroid_col = found_r ? qcol_r : '0;
          out_nxt.centroid_row = found_r ? q_r : '0;
          out_nxt.pixel_count  = cnt_hold_r;
          state_nxt            = hsvbc_pkg::ST_RUN;
        end
      end
      default: state_nxt = hsvbc_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hsvbc_pkg::ST_RUN;
      col_sum_r   <= '0;
      row_sum_r   <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_sum_r   <= col_sum_nxt;
      row_sum_r   <= row_sum_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    row_hold_r <= row_hold_nxt;
    cnt_hold_r <= cnt_hold_nxt;
    q_r        <= q_nxt;
    qcol_r     <= qcol_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // last beat of a frame always hands off to the divider or result stage
  `HSVBC_CHECK(a_last_leaves_run,
    in_valid && !in_stall && in_data.frame_end |=> state_r != hsvbc_pkg::ST_RUN,
    "frame end did not stop input")
  // a new result only comes out of the result stage
  `HSVBC_CHECK(a_out_from_stage,
    $rose(out_valid) |-> $past(state_r == hsvbc_pkg::ST_OUT),
    "result raised outside result stage")
  // quotient fits in 8 bits: remainder stays below twice the shifted divisor
  `HSVBC_CHECK(a_div_bound,
    (state_r == hsvbc_pkg::ST_DIVC || state_r == hsvbc_pkg::ST_DIVR) |->
      ({1'b0, rem_r} < {dsh_r, 1'b0}),
    "divider remainder out of range")
  `HSVBC_CHECK(a_div_col_to_row,
    state_r == hsvbc_pkg::ST_DIVC && step_r == 3'd0 |=> state_r == hsvbc_pkg::ST_DIVR,
    "column division did not hand off to row")
  `HSVBC_CHECK(a_not_found_zero,
    out_valid && !out_data.object_found |->
      out_data.centroid_col == 8'd0 && out_data.centroid_row == 8'd0,
    "centroid nonzero without object")

endmodule

`default_nettype wire

### bench/hsv_window_blob_centroid_core_checker.sv
module hsv_window_blob_centroid_core_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  hsvbc_pkg::pix_t               in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  hsvbc_pkg::res_t               out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [hsvbc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = hsvbc_pkg::SUM_W;
  localparam int CW = hsvbc_pkg::COUNT_W;

  logic [7:0]                    hue_hi, hue_lo, sat_hi, sat_lo, val_hi, val_lo;
  logic [hsvbc_pkg::MINPX_W-1:0] min_hits;

  logic [SW-1:0] col_acc, row_acc;
  logic [CW-1:0] hits;

  hsvbc_pkg::res_t centroid_q[$];
  int              fails = 0;

  function automatic logic pixel_marked(hsvbc_pkg::pix_t p);
    return p.hue >= hue_lo && p.hue <= hue_hi &&
           p.saturation >= sat_lo && p.saturation <= sat_hi &&
           p.brightness >= val_lo && p.brightness <= val_hi &&
           32'(p.col) < hsvbc_pkg::MAX_COLS && 32'(p.row) < hsvbc_pkg::MAX_ROWS;
  endfunction

  task automatic compare_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : monitor
    hsvbc_pkg::res_t want;
    logic [SW:0]     col_next, row_next;
    if (!rst_n) begin
      hue_hi   = hsvbc_pkg::HUE_MAX_RST;
      hue_lo   = hsvbc_pkg::HUE_MIN_RST;
      sat_hi   = hsvbc_pkg::SAT_MAX_RST;
      sat_lo   = hsvbc_pkg::SAT_MIN_RST;
      val_hi   = hsvbc_pkg::VAL_MAX_RST;
      val_lo   = hsvbc_pkg::VAL_MIN_RST;
      min_hits = hsvbc_pkg::MINPX_RST;
      col_acc  = '0;
      row_acc  = '0;
      hits     = '0;
      centroid_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          hsvbc_pkg::REG_HUE_MAX: hue_hi = pwdata[7:0];
          hsvbc_pkg::REG_HUE_MIN: hue_lo = pwdata[7:0];
          hsvbc_pkg::REG_SAT_MAX: sat_hi = pwdata[7:0];
          hsvbc_pkg::REG_SAT_MIN: sat_lo = pwdata[7:0];
          hsvbc_pkg::REG_VAL_MAX: val_hi = pwdata[7:0];
          hsvbc_pkg::REG_VAL_MIN: val_lo = pwdata[7:0];
          hsvbc_pkg::REG_MINPX:   min_hits = pwdata[hsvbc_pkg::MINPX_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (pixel_marked(in_data)) begin
          // accumulators clamp at full scale instead of wrapping
          col_next = {1'b0, col_acc} + (SW+1)'(in_data.col);
          row_next = {1'b0, row_acc} + (SW+1)'(in_data.row);
          col_acc  = col_next[SW] ? '1 : col_next[SW-1:0];
          row_acc  = row_next[SW] ? '1 : row_next[SW-1:0];
          if (hits != '1) hits = hits + CW'(1);
        end
        if (in_data.frame_end) begin
          want = '0;
          want.pixel_count = hits;
          if (hits > CW'(min_hits)) begin
            want.object_found = 1'b1;
            want.centroid_col = 8'(col_acc / SW'(hits));
            want.centroid_row = 8'(row_acc / SW'(hits));
          end
          centroid_q = {centroid_q, want};
          col_acc = '0;
          row_acc = '0;
          hits    = '0;
        end
      end

      if (out_valid && !out_stall) begin
        if (centroid_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: got %p", $time, out_data);
          fails++;
        end else begin
          want = centroid_q.pop_front();
          compare_field("object_found", CW'(want.object_found),
                        CW'(out_data.object_found));
          compare_field("centroid_col", CW'(want.centroid_col),
                        CW'(out_data.centroid_col));
          compare_field("centroid_row", CW'(want.centroid_row),
                        CW'(out_data.centroid_row));
          compare_field("pixel_count", want.pixel_count, out_data.pixel_count);
        end
      end
    end
    pending <= centroid_q.size();
    errors  <= fails;
  end

endmodule

### bench/hsv_window_blob_centroid_core_tb.sv
module hsv_window_blob_centroid_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RAND_ITEMS    = 1400;
  localparam int RAND_FRAMES   = 48;
  localparam int HOLD_CYCLES   = 500;
  localparam int CH_HUE        = 0;
  localparam int CH_SAT        = 1;
  localparam int CH_VAL        = 2;
  localparam logic [hsvbc_pkg::PADDR_W-1:0] UNMAPPED_ADDR = 5'd28;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  hsvbc_pkg::pix_t               in_data;
  logic                          out_valid;
  logic                          out_stall;
  hsvbc_pkg::res_t               out_data;
  logic                          psel, penable, pwrite;
  logic [hsvbc_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  int errors;
  int pending;
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  // stimulus-side copy of the color window, used to aim pixels inside it
  logic [7:0] win_lo[3];
  logic [7:0] win_hi[3];

  hsv_window_blob_centroid_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  hsv_window_blob_centroid_core_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic hsvbc_pkg::pix_t mk(logic [7:0] h, logic [7:0] s, logic [7:0] b,
                                         logic [7:0] c, logic [7:0] r, logic last);
    hsvbc_pkg::pix_t p;
    p.hue        = h;
    p.saturation = s;
    p.brightness = b;
    p.col        = c;
    p.row        = r;
    p.frame_end  = last;
    return p;
  endfunction

  function automatic logic [7:0] pick(logic [7:0] lo, logic [7:0] hi, bit aim);
    if (aim && lo <= hi) begin
      case ($urandom_range(0, 3))
        0:       return lo;
        1:       return hi;
        default: return 8'($urandom_range(hi, lo));
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return lo - 8'd1;
      1:       return hi + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic hsvbc_pkg::pix_t rand_pixel();
    bit              aim;
    hsvbc_pkg::pix_t p;
    aim = $urandom_range(0, 99) < 70;
    p = mk(pick(win_lo[CH_HUE], win_hi[CH_HUE], aim),
           pick(win_lo[CH_SAT], win_hi[CH_SAT], aim),
           pick(win_lo[CH_VAL], win_hi[CH_VAL], aim),
           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    return p;
  endfunction

  task automatic apb_write(logic [hsvbc_pkg::PADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_reg(hsvbc_pkg::reg_idx_t r, int unsigned v);
    logic [31:0] msk;
    msk = (r == hsvbc_pkg::REG_MINPX) ? 32'h3FF : 32'hFF;
    case (r)
      hsvbc_pkg::REG_HUE_MAX: win_hi[CH_HUE] = v[7:0];
      hsvbc_pkg::REG_HUE_MIN: win_lo[CH_HUE] = v[7:0];
      hsvbc_pkg::REG_SAT_MAX: win_hi[CH_SAT] = v[7:0];
      hsvbc_pkg::REG_SAT_MIN: win_lo[CH_SAT] = v[7:0];
      hsvbc_pkg::REG_VAL_MAX: win_hi[CH_VAL] = v[7:0];
      hsvbc_pkg::REG_VAL_MIN: win_lo[CH_VAL] = v[7:0];
      default: ;
    endcase
    // junk in the unused upper bits must be dropped by the block
    apb_write({r, 2'b00}, ($urandom() & ~msk) | (v & msk));
  endtask

  task automatic rand_window(hsvbc_pkg::reg_idx_t hi_reg, hsvbc_pkg::reg_idx_t lo_reg);
    logic [7:0] a, b;
    a = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0: begin
        a = 8'd0;
        b = 8'd255;
      end
      1, 2: if (a > b) {a, b} = {b, a};
      3: ;
      default: b = a;
    endcase
    set_reg(hi_reg, 32'(b));
    set_reg(lo_reg, 32'(a));
  endtask

  task automatic send_pix(hsvbc_pkg::pix_t p);
    int gap;
    if (idle_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_frame(int len);
    hsvbc_pkg::pix_t p;
    for (int i = 0; i < len; i++) begin
      p = rand_pixel();
      p.frame_end = (i == len - 1);
      send_pix(p);
    end
  endtask

  // wait for every outstanding frame result, then let the divider drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    int mode;
    int span;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off: the next frame's result waits behind the held one and stalls the input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        if (hold_req && !hold_done) break;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= $urandom_range(0, 99) < 30;
          2:       out_stall <= $urandom_range(0, 99) < 75;
          default: out_stall <= $urandom_range(0, 7) == 0;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int rand_start;
    int rand_frames;
    int phase;
    int nframes;
    int len;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    win_lo[CH_HUE] = hsvbc_pkg::HUE_MIN_RST;
    win_hi[CH_HUE] = hsvbc_pkg::HUE_MAX_RST;
    win_lo[CH_SAT] = hsvbc_pkg::SAT_MIN_RST;
    win_hi[CH_SAT] = hsvbc_pkg::SAT_MAX_RST;
    win_lo[CH_VAL] = hsvbc_pkg::VAL_MIN_RST;
    win_hi[CH_VAL] = hsvbc_pkg::VAL_MAX_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window: value 225 is in, 224 is out; two marked is below 13
    send_pix(mk(8'd0, 8'd0, 8'd225, 8'd0, 8'd0, 1'b0));
    send_pix(mk(8'd255, 8'd255, 8'd224, 8'd17, 8'd9, 1'b0));
    send_pix(mk(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    settle();

    // zero threshold: one marked pixel reports, zero marked does not
    set_reg(hsvbc_pkg::REG_MINPX, 0);
    send_pix(mk(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b1));
    send_pix(mk(8'd0, 8'd0, 8'd0, 8'd200, 8'd100, 1'b1));
    settle();

    set_reg(hsvbc_pkg::REG_VAL_MIN, 0);
    send_pix(mk(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
    send_pix(mk(8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 1'b1));
    settle();

    // count equal to the threshold, then one above it
    set_reg(hsvbc_pkg::REG_MINPX, 2);
    send_frame(2);
    send_frame(3);
    settle();

    // inverted hue window marks nothing
    set_reg(hsvbc_pkg::REG_HUE_MIN, 200);
    set_reg(hsvbc_pkg::REG_HUE_MAX, 100);
    send_pix(mk(8'd150, 8'd0, 8'd0, 8'd5, 8'd5, 1'b0));
    send_pix(mk(8'd100, 8'd0, 8'd0, 8'd5, 8'd5, 1'b0));
    send_pix(mk(8'd200, 8'd0, 8'd0, 8'd5, 8'd5, 1'b1));
    settle();

    // single-value windows on every channel
    set_reg(hsvbc_pkg::REG_HUE_MIN, 100);
    set_reg(hsvbc_pkg::REG_SAT_MAX, 7);
    set_reg(hsvbc_pkg::REG_SAT_MIN, 7);
    set_reg(hsvbc_pkg::REG_VAL_MAX, 9);
    set_reg(hsvbc_pkg::REG_VAL_MIN, 9);
    send_pix(mk(8'd100, 8'd7, 8'd9, 8'd40, 8'd60, 1'b0));
    send_pix(mk(8'd101, 8'd7, 8'd9, 8'd40, 8'd60, 1'b0));
    send_pix(mk(8'd100, 8'd6, 8'd9, 8'd40, 8'd60, 1'b0));
    send_pix(mk(8'd100, 8'd7, 8'd10, 8'd40, 8'd60, 1'b1));
    settle();

    // threshold beyond its nominal range, and a write to an unmapped slot
    set_reg(hsvbc_pkg::REG_MINPX, 1023);
    apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    send_pix(mk(8'd100, 8'd7, 8'd9, 8'd250, 8'd2, 1'b0));
    send_pix(mk(8'd100, 8'd7, 8'd9, 8'd251, 8'd3, 1'b1));
    settle();

    rand_start  = items_sent;
    rand_frames = 0;
    phase       = 0;
    while (items_sent - rand_start < RAND_ITEMS || rand_frames < RAND_FRAMES) begin
      if (phase > 0) settle();
      if ($urandom_range(0, 9) < 6)
        rand_window(hsvbc_pkg::REG_HUE_MAX, hsvbc_pkg::REG_HUE_MIN);
      if ($urandom_range(0, 9) < 6)
        rand_window(hsvbc_pkg::REG_SAT_MAX, hsvbc_pkg::REG_SAT_MIN);
      if ($urandom_range(0, 9) < 6)
        rand_window(hsvbc_pkg::REG_VAL_MAX, hsvbc_pkg::REG_VAL_MIN);
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 5))
          0:       set_reg(hsvbc_pkg::REG_MINPX, 0);
          1:       set_reg(hsvbc_pkg::REG_MINPX, 1023);
          2:       set_reg(hsvbc_pkg::REG_MINPX, $urandom_range(0, 1000));
          default: set_reg(hsvbc_pkg::REG_MINPX, $urandom_range(0, 25));
        endcase
      end
      if ($urandom_range(0, 9) == 0) apb_write(UNMAPPED_ADDR, $urandom());
      if (phase == 1) hold_req = 1'b1;
      nframes = $urandom_range(2, 6);
      for (int f = 0; f < nframes; f++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        send_frame(len);
        rand_frames++;
      end
      phase++;
    end
    settle();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
